### src/lcmacc_pkg.sv
// Package for the running LCM accumulator.
// Holds the fixed widths of the limit register and the result field and the limit's reset value.
// No dependencies.
package lcmacc_pkg;

    localparam int unsigned LIMIT_WIDTH = 32;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 32'd50;
    localparam int unsigned LCM_WIDTH = 32;

endpackage

### src/lcmacc_divider.sv
// Iterative restoring divider shared by the Euclid steps and the quotient step.
// Produces one quotient bit per cycle; no package dependencies.
module lcmacc_divider #(
    parameter int unsigned WIDTH = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int unsigned CNT_WIDTH = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]     rem_reg, rem_next;
    logic [WIDTH-1:0]     quo_reg, quo_next;
    logic [WIDTH-1:0]     div_reg, div_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [WIDTH:0]       trial;
    logic [WIDTH:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = CNT_WIDTH'(WIDTH);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next  = {quo_reg[WIDTH-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### src/running_lcm_accumulator_top.sv
// Top level of the running LCM accumulator.
// Depends on lcmacc_pkg and instantiates lcmacc_divider.
//
// Each request carries one positive integer and a last mark and yields one result with the
// running least common multiple, a sticky overflow flag, a within-limit flag and the last mark.
// The block handles one request at a time. A seed, a zero, or a request after an overflow goes
// straight to the finish state. A fold runs Euclid on one shared restoring divider, one
// quotient bit per cycle: (k + 1) divisions on W-bit operands, where k is the number of
// remainder steps and W the wider of the two operand widths, then a division of the accumulator
// by the GCD and a shift-add multiply by the new value, then the result is written out.
module running_lcm_accumulator_top #(
    parameter int unsigned VALUE_WIDTH = 16,
    parameter int unsigned ACC_WIDTH   = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]          s_tdata,  // value
    input  logic                                      s_tlast,  // last
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [lcmacc_pkg::LCM_WIDTH-1:0]          m_tdata,  // running_lcm
    output logic [1:0]                                m_tuser,  // overflow, within_limit
    output logic                                      m_tlast,  // last_out
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [lcmacc_pkg::LIMIT_WIDTH-1:0]        cfg_data  // year_limit
);

    localparam int unsigned W    = (ACC_WIDTH > VALUE_WIDTH) ? ACC_WIDTH : VALUE_WIDTH;
    localparam int unsigned P    = ACC_WIDTH + VALUE_WIDTH;
    localparam int unsigned LW   = lcmacc_pkg::LIMIT_WIDTH;
    localparam int unsigned OW   = lcmacc_pkg::LCM_WIDTH;
    localparam int unsigned CW   = (ACC_WIDTH > LW) ? ACC_WIDTH : LW;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {ACC_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_QUO,
        ST_MUL,
        ST_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic                   started_reg, started_next;
    logic                   ovf_reg, ovf_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic                   last_reg, last_next;
    logic [LW-1:0]          limit_reg, limit_next;
    logic                   start_reg, start_next;
    logic [W-1:0]           opa_reg, opa_next;
    logic [W-1:0]           opb_reg, opb_next;
    logic [P-1:0]           mcand_reg, mcand_next;
    logic [VALUE_WIDTH-1:0] mplier_reg, mplier_next;
    logic [P-1:0]           prod_reg, prod_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OW-1:0]          m_lcm_reg, m_lcm_next;
    logic                   m_ovf_reg, m_ovf_next;
    logic                   m_within_reg, m_within_next;
    logic                   m_last_reg, m_last_next;

    logic                   div_done;
    logic [W-1:0]           div_quo;
    logic [W-1:0]           div_rem;
    logic [VALUE_WIDTH-1:0] s_value;
    logic                   in_accept;
    logic                   in_limit;

    lcmacc_divider #(
        .WIDTH(W)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (opa_reg),
        .divisor   (opb_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_value   = s_tdata[VALUE_WIDTH-1:0];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign in_limit  = last_reg && !ovf_reg && (acc_reg != '0) &&
                       (CW'(acc_reg) <= CW'(limit_reg));

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        started_next  = started_reg;
        ovf_next      = ovf_reg;
        v_next        = v_reg;
        last_next     = last_reg;
        limit_next    = limit_reg;
        start_next    = 1'b0;
        opa_next      = opa_reg;
        opb_next      = opb_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg;
        m_lcm_next    = m_lcm_reg;
        m_ovf_next    = m_ovf_reg;
        m_within_next = m_within_reg;
        m_last_next   = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    v_next     = s_value;
                    last_next  = s_tlast;
                    state_next = ST_FINISH;
                    if (!started_reg) begin
                        started_next = 1'b1;
                        if (W'(s_value) > W'(ACC_MAX)) begin
                            acc_next = ACC_MAX;
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = ACC_WIDTH'(s_value);
                        end
                    end else if (!ovf_reg) begin
                        if (acc_reg == '0 || s_value == '0) begin
                            acc_next = '0;
                        end else begin
                            opa_next   = W'(acc_reg);
                            opb_next   = W'(s_value);
                            start_next = 1'b1;
                            state_next = ST_GCD;
                        end
                    end
                end
            end
            ST_GCD: begin
                if (div_done) begin
                    start_next = 1'b1;
                    if (div_rem == '0) begin
                        opa_next   = W'(acc_reg);
                        state_next = ST_QUO;
                    end else begin
                        opa_next = opb_reg;
                        opb_next = div_rem;
                    end
                end
            end
            ST_QUO: begin
                if (div_done) begin
                    mcand_next  = P'(div_quo[ACC_WIDTH-1:0]);
                    mplier_next = v_reg;
                    prod_next   = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg == '0) begin
                    if (prod_reg[P-1:ACC_WIDTH] != '0) begin
                        acc_next = ACC_MAX;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod_reg[ACC_WIDTH-1:0];
                    end
                    state_next = ST_FINISH;
                end else begin
                    if (mplier_reg[0]) begin
                        prod_next = prod_reg + mcand_reg;
                    end
                    mcand_next  = {mcand_reg[P-2:0], 1'b0};
                    mplier_next = {1'b0, mplier_reg[VALUE_WIDTH-1:1]};
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_lcm_next    = OW'(acc_reg);
                    m_ovf_next    = ovf_reg;
                    m_within_next = in_limit;
                    m_last_next   = last_reg;
                    if (last_reg) begin
                        acc_next     = '0;
                        started_next = 1'b0;
                        ovf_next     = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            started_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            limit_reg   <= lcmacc_pkg::LIMIT_RESET;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            started_reg <= started_next;
            ovf_reg     <= ovf_next;
            limit_reg   <= limit_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        v_reg        <= v_next;
        last_reg     <= last_next;
        opa_reg      <= opa_next;
        opb_reg      <= opb_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        m_lcm_reg    <= m_lcm_next;
        m_ovf_reg    <= m_ovf_next;
        m_within_reg <= m_within_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_lcm_reg;
    assign m_tuser  = {m_within_reg, m_ovf_reg};
    assign m_tlast  = m_last_reg;

endmodule
